// ===== rtl/afsk_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the elaborated sine table for the AFSK modulator.
// No dependencies; used by the top level, the checker and the bench.
package afsk_pkg;

  localparam int TABLE_DEPTH    = 256;
  localparam int SINE_AMPLITUDE = 16000;
  localparam int MAX_RUN        = 64;

  localparam int SAMPLE_W = 16;
  localparam int PHASE_W  = 32;
  localparam int SYM_W    = 18;
  localparam int RATE_W   = 17;
  localparam int TBL_AW   = $clog2(TABLE_DEPTH);
  localparam int RUN_W    = $clog2(MAX_RUN);
  localparam int QUARTER  = TABLE_DEPTH / 4;
  localparam int CFG_AW   = 2;

  localparam logic [PHASE_W-1:0] MARK_STEP_RST  = 32'd107374182;
  localparam logic [PHASE_W-1:0] SPACE_STEP_RST = 32'd196852667;
  localparam logic [RATE_W-1:0]  BAUD_INC_RST   = 17'd1200;
  localparam logic [RATE_W-1:0]  SAMPLE_RATE_RST = 17'd48000;

  // Fixed-point constants for building the sine table at elaboration.
  localparam longint unsigned PI_Q32       = 64'd13493037704;
  localparam longint unsigned ONE_Q30      = 64'd1073741824;
  localparam int              SERIES_TERMS = 8;

  typedef enum logic [CFG_AW-1:0] {
    REG_MARK_STEP   = 2'd0,
    REG_SPACE_STEP  = 2'd1,
    REG_BAUD_INC    = 2'd2,
    REG_SAMPLE_RATE = 2'd3
  } cfg_reg_t;

  typedef logic [SAMPLE_W-1:0] sine_tbl_t [TABLE_DEPTH];

  // Quarter-wave magnitude from a truncating Taylor series in Q30.
  function automatic longint unsigned quarter_mag(longint unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    x    = (k * PI_Q32) >> 9;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1: term = term / 6;
        2: term = term / 20;
        3: term = term / 42;
        4: term = term / 72;
        5: term = term / 110;
        6: term = term / 156;
        7: term = term / 210;
        8: term = term / 272;
        default: term = term;
      endcase
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum > ONE_Q30) begin
      sum = ONE_Q30;
    end
    return (sum * SINE_AMPLITUDE) >> 30;
  endfunction

  function automatic sine_tbl_t build_sine_table();
    sine_tbl_t     tbl;
    longint signed v;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i < QUARTER) begin
        v = longint'(quarter_mag(longint'(i)));
      end else if (i < 2 * QUARTER) begin
        v = longint'(quarter_mag(longint'(2 * QUARTER - i)));
      end else if (i < 3 * QUARTER) begin
        v = -longint'(quarter_mag(longint'(i - 2 * QUARTER)));
      end else begin
        v = -longint'(quarter_mag(longint'(TABLE_DEPTH - i)));
      end
      tbl[i] = v[SAMPLE_W-1:0];
    end
    return tbl;
  endfunction

  localparam sine_tbl_t SINE_TABLE = build_sine_table();

endpackage

// ===== rtl/afsk_nco_modulator.sv =====
`timescale 1ns / 1ps
// AFSK NCO modulator top level: config registers, NCO state and sample sequencing.
// Depends on afsk_pkg and afsk_ram (sine memory).
// The first sample of a run is read into the sine memory's read register, then moved to the output register.
// Throughput: one sample per cycle while out_stall is low; a bit gives N samples (N <= 64),
// and the next bit is taken only once its last sample has left the output register.
// Reset: after rst_n the sine memory is loaded from the built-in table, all 256 entries,
// during which in_stall is high; config writes are taken at all times.
module afsk_nco_modulator import afsk_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_tx_bit,
  input  logic                       in_frame_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       out_last_of_run,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_AW-1:0]          cfg_addr,
  input  logic [31:0]                cfg_wdata
);

  // Configuration registers.
  logic [PHASE_W-1:0] mark_r, space_r;
  logic [RATE_W-1:0]  baud_r, rate_r;

  // NCO state and run control.
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [PHASE_W-1:0] step_r, step_nxt;
  logic [SYM_W-1:0]   sym_r, sym_nxt;
  logic [RUN_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               bit_r, fend_r;

  // Sine memory load after reset.
  logic              init_r;
  logic [TBL_AW-1:0] init_cnt_r;

  // Read stage and output register.
  logic                rd_vld_r, rd_vld_nxt;
  logic                rd_last_r;
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic                out_last_r;
  logic [SAMPLE_W-1:0] ram_rdata;

  logic [SYM_W-1:0]   acc;
  logic               reach, forced, taken;
  logic [PHASE_W-1:0] step_use, phase_sum;
  logic               fire, move, in_acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r  <= MARK_STEP_RST;
      space_r <= SPACE_STEP_RST;
      baud_r  <= BAUD_INC_RST;
      rate_r  <= SAMPLE_RATE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_MARK_STEP:   mark_r  <= cfg_wdata;
        REG_SPACE_STEP:  space_r <= cfg_wdata;
        REG_BAUD_INC:    baud_r  <= cfg_wdata[RATE_W-1:0];
        REG_SAMPLE_RATE: rate_r  <= cfg_wdata[RATE_W-1:0];
      endcase
    end
  end

  // Symbol accumulator step and bit-take decision for the sample being issued.
  // The sum wraps at the accumulator width.
  assign acc       = sym_r + {{(SYM_W - RATE_W){1'b0}}, baud_r};
  assign reach     = acc >= {{(SYM_W - RATE_W){1'b0}}, rate_r};
  assign forced    = cnt_r == RUN_W'(MAX_RUN - 1);
  assign taken     = reach || forced;
  assign step_use  = taken ? (bit_r ? mark_r : space_r) : step_r;
  assign phase_sum = phase_r + step_use;

  // A pending read moves into the output register when that register frees up;
  // a new read is issued only if the read data register will not be overwritten.
  assign move     = rd_vld_r && (!out_valid_r || !out_stall);
  assign fire     = busy_r && (!rd_vld_r || move);
  assign in_stall = init_r || busy_r || rd_vld_r || out_valid_r;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    phase_nxt     = phase_r;
    step_nxt      = step_r;
    sym_nxt       = sym_r;
    cnt_nxt       = cnt_r;
    busy_nxt      = busy_r;
    rd_vld_nxt    = fire || (rd_vld_r && !move);
    out_valid_nxt = move || (out_valid_r && out_stall);
    if (in_acc) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end
    if (fire) begin
      cnt_nxt   = cnt_r + RUN_W'(1);
      phase_nxt = phase_sum;
      step_nxt  = step_use;
      if (reach) begin
        sym_nxt = acc - {{(SYM_W - RATE_W){1'b0}}, rate_r};
      end else if (forced) begin
        sym_nxt = '0;
      end else begin
        sym_nxt = acc;
      end
      if (taken) begin
        busy_nxt = 1'b0;
        if (fend_r) begin
          phase_nxt = '0;
          sym_nxt   = '0;
          step_nxt  = mark_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      step_r      <= MARK_STEP_RST;
      sym_r       <= '0;
      cnt_r       <= '0;
      busy_r      <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      init_r      <= 1'b1;
      init_cnt_r  <= '0;
    end else begin
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      sym_r       <= sym_nxt;
      cnt_r       <= cnt_nxt;
      busy_r      <= busy_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (init_r) begin
        init_cnt_r <= init_cnt_r + TBL_AW'(1);
        if (init_cnt_r == TBL_AW'(TABLE_DEPTH - 1)) begin
          init_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      bit_r  <= in_tx_bit;
      fend_r <= in_frame_end;
    end
    if (fire) begin
      rd_last_r <= taken;
    end
    if (move) begin
      out_sample_r <= ram_rdata;
      out_last_r   <= rd_last_r;
    end
  end

  afsk_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(TABLE_DEPTH)
  ) u_sine_ram (
    .clk  (clk),
    .we   (init_r),
    .waddr(init_cnt_r),
    .wdata(SINE_TABLE[init_cnt_r]),
    .re   (fire),
    .raddr(phase_sum[PHASE_W-1 -: TBL_AW]),
    .rdata(ram_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_sample      = $signed(out_sample_r);
  assign out_last_of_run = out_last_r;

endmodule

// ===== rtl/afsk_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package dependencies.
module afsk_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/afsk_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the AFSK modulator, bound to the top level.
// Depends on afsk_pkg for field widths.
module afsk_checker import afsk_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [SAMPLE_W-1:0] out_sample,
  input logic                       out_last_of_run
);

  // A stalled output beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample) && $stable(out_last_of_run))
    else $error("output beat changed while stalled");

  // Only one bit is worked on at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second input beat accepted back to back");

  // While a run is not finished, no new bit is taken.
  a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> in_stall)
    else $error("input accepted before the run's last sample");

  // When the block takes input, every earlier sample has been delivered.
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("input ready while a sample is pending");

endmodule

bind afsk_nco_modulator afsk_checker u_afsk_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for afsk_nco_modulator: feeds line bits and register writes,
// predicts every audio sample of each run and compares it on the result channel.
// Depends on afsk_pkg and the modulator RTL only.
module tb;
  import afsk_pkg::*;

  localparam int CYCLE_LIMIT    = 1000000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_PHASES  = 8;
  localparam int BITS_PER_PHASE = 25;
  localparam int RATE_MAX       = 131071;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } tone_t;

  // Tracks the oscillator state and holds the samples still owed by the block.
  class nco_tone_tracker;
    logic [PHASE_W-1:0]  mark_step;
    logic [PHASE_W-1:0]  space_step;
    logic [RATE_W-1:0]   baud;
    logic [RATE_W-1:0]   rate;
    logic [PHASE_W-1:0]  phase;
    logic [PHASE_W-1:0]  step;
    logic [SYM_W-1:0]    sym_acc;
    logic [SAMPLE_W-1:0] sine [TABLE_DEPTH];
    tone_t               expected_tones [$];
    int                  mismatches;

    function new();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      int              quarter [QUARTER+1];
      int              m;
      int              mag;
      // Quarter wave from a truncating Taylor series in Q30, then mirrored.
      for (int k = 0; k <= QUARTER; k++) begin
        x    = (longint'(k) * PI_Q32) >> 9;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 8; n++) begin
          term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
        if (sum > ONE_Q30) begin
          sum = ONE_Q30;
        end
        quarter[k] = int'((sum * longint'(SINE_AMPLITUDE)) >> 30);
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        m   = i % (2 * QUARTER);
        mag = quarter[(m < QUARTER) ? m : 2 * QUARTER - m];
        sine[i] = SAMPLE_W'((i < 2 * QUARTER) ? mag : -mag);
      end
      mark_step  = MARK_STEP_RST;
      space_step = SPACE_STEP_RST;
      baud       = BAUD_INC_RST;
      rate       = SAMPLE_RATE_RST;
      phase      = '0;
      sym_acc    = '0;
      step       = MARK_STEP_RST;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [31:0] val);
      case (idx)
        REG_MARK_STEP:   mark_step  = val;
        REG_SPACE_STEP:  space_step = val;
        REG_BAUD_INC:    baud       = val[RATE_W-1:0];
        REG_SAMPLE_RATE: rate       = val[RATE_W-1:0];
        default: ;
      endcase
    endfunction

    function void bit_accepted(logic tx_bit, logic frame_end);
      logic [SYM_W-1:0] acc;
      bit               taken;
      int               count;
      tone_t            t;
      taken = 1'b0;
      count = 0;
      while (!taken && count < MAX_RUN) begin
        acc = sym_acc + baud;
        if (acc >= rate) begin
          acc   = acc - rate;
          taken = 1'b1;
        end else if (count == MAX_RUN - 1) begin
          // Bit is forced out on the last sample a run may have.
          acc   = '0;
          taken = 1'b1;
        end
        sym_acc = acc;
        if (taken) begin
          step = tx_bit ? mark_step : space_step;
        end
        phase    = phase + step;
        t.sample = sine[phase[PHASE_W-1 -: TBL_AW]];
        t.last   = taken;
        expected_tones.push_back(t);
        count++;
      end
      if (frame_end) begin
        phase   = '0;
        sym_acc = '0;
        step    = mark_step;
      end
    endfunction

    function void sample_seen(logic [SAMPLE_W-1:0] sample, logic last);
      tone_t e;
      if (expected_tones.size() == 0) begin
        $display("%0t: unexpected sample %0d last_of_run %0b", $time, $signed(sample), last);
        mismatches++;
        return;
      end
      e = expected_tones.pop_front();
      if (sample !== e.sample) begin
        $display("%0t: sample expected %0d actual %0d", $time, $signed(e.sample),
                 $signed(sample));
        mismatches++;
      end
      if (last !== e.last) begin
        $display("%0t: last_of_run expected %0b actual %0b", $time, e.last, last);
        mismatches++;
      end
    endfunction

    function int backlog();
      return expected_tones.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_tx_bit;
  logic                       in_frame_end;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_last_of_run;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_AW-1:0]          cfg_addr;
  logic [31:0]                cfg_wdata;

  nco_tone_tracker tracker;
  bit              in_gaps;
  bit              out_gaps;
  int              cycles;

  afsk_nco_modulator u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_tx_bit       (in_tx_bit),
    .in_frame_end    (in_frame_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample      (out_sample),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.sample_seen(out_sample, out_last_of_run);
    end
  end

  // Receiver side: a random hold-off before each beat, none while gaps are off.
  initial begin
    int n;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      n = out_gaps ? $urandom_range(0, 7) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat with valid high.
  task automatic send_bit(input logic tx_bit, input logic frame_end);
    int gap;
    gap = in_gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_tx_bit    <= tx_bit;
    in_frame_end <= frame_end;
    do @(posedge clk); while (in_stall);
    tracker.bit_accepted(tx_bit, frame_end);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [31:0] mark, input logic [31:0] space,
                              input logic [31:0] baud, input logic [31:0] rate);
    write_reg(REG_MARK_STEP, mark);
    write_reg(REG_SPACE_STEP, space);
    write_reg(REG_BAUD_INC, baud);
    write_reg(REG_SAMPLE_RATE, rate);
    cfg_valid <= 1'b0;
  endtask

  // Registers only change once every owed sample is out and the pipeline is empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.backlog() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_settings();
    logic [31:0] baud;
    logic [31:0] rate;
    if ($urandom_range(0, 7) == 0) begin
      baud = $urandom_range(0, RATE_MAX);
      rate = $urandom_range(0, RATE_MAX);
    end else begin
      // Keep the rate a small multiple of the baud so most runs are short.
      baud = $urandom_range(1, 8191);
      rate = baud * $urandom_range(1, 16) + $urandom_range(0, baud - 1);
      if (rate > RATE_MAX) begin
        rate = RATE_MAX;
      end
    end
    // Bits above the register width must be dropped by the block.
    baud[31:RATE_W] = (32 - RATE_W)'($urandom);
    rate[31:RATE_W] = (32 - RATE_W)'($urandom);
    program_regs($urandom, $urandom, baud, rate);
  endtask

  initial begin
    tracker      = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_tx_bit    = 1'b0;
    in_frame_end = 1'b0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_addr     = REG_MARK_STEP;
    cfg_wdata    = '0;
    in_gaps      = 1'b1;
    out_gaps     = 1'b1;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: forty samples per bit, frame ends in the middle.
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b0);
    send_bit(1'b0, 1'b0);
    send_bit(1'b1, 1'b1);
    send_bit(1'b0, 1'b0);
    send_bit(1'b1, 1'b0);
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b1);

    // Baud far above the rate: the symbol accumulator wraps.
    drain();
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    program_regs(32'h0000_0000, 32'hFFFF_FFFF, RATE_MAX, 32'd1);
    send_bit(1'b0, 1'b0);
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b0);
    send_bit(1'b1, 1'b1);

    // Zero baud: every bit leaves through the forced take.
    drain();
    in_gaps = 1'b1;
    program_regs(32'hFFFF_FFFF, 32'h0000_0000, 32'd0, RATE_MAX);
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b0);
    send_bit(1'b1, 1'b1);

    // Zero rate: the threshold is always met, one sample per bit.
    drain();
    out_gaps = 1'b1;
    program_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0);
    send_bit(1'b0, 1'b0);
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b1);
    send_bit(1'b1, 1'b0);

    // Baud equal to the largest rate.
    drain();
    program_regs(32'h0123_4567, 32'hFEDC_BA98, RATE_MAX, RATE_MAX);
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b0);
    send_bit(1'b1, 1'b1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      random_settings();
      in_gaps  = ($urandom_range(0, 3) != 0);
      out_gaps = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < BITS_PER_PHASE; k++) begin
        send_bit(1'($urandom_range(0, 1)), ($urandom_range(0, 7) == 0));
      end
    end
    drain();

    if (tracker.mismatches == 0 && tracker.backlog() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
